// ===== src/fpip_pkg.sv =====
// ----------------------------------------------------------------------------
// fpip_pkg
// Shared types and constants for the fixed point integer power block.
// ----------------------------------------------------------------------------
package fpip_pkg;

  localparam int DataW       = 32;
  localparam int ProdW       = 2 * DataW;
  localparam int ExpFracBits = 29;
  localparam int RoundShift  = 24;
  localparam int StepW       = 2;
  localparam int MaxSteps    = 3;
  // reciprocal numerator is 2^50, handled two quotient bits per cycle over 52 bits
  localparam int DivIters    = 26;
  localparam int DivCntW     = 5;

  localparam logic [DataW-1:0] OneQ15 = 32'h0000_8000;
  localparam logic [DataW-1:0] SatMax = 32'h7fff_ffff;
  localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_RECIP,
    S_MUL,
    S_RND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_first;
    logic recip;
    logic mul;
    logic rnd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic             need_div;
    logic [StepW-1:0] steps;
  } status_t;

endpackage

// ===== src/fixed_point_integer_power.sv =====
// ----------------------------------------------------------------------------
// fixed_point_integer_power
// Raises a Q6.25 base to the integer part of a Q2.29 exponent, Q16.15 out.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with in_base and in_exponent. Output
// channel: out_valid/out_ready with out_power and out_divide_by_zero.
// One word is worked on at a time; in_ready is high only while idle.
// Let n be the step count (integer exponent magnitude, limited to 3).
// A non-negative exponent, or a zero base, goes from acceptance through
// setup and n multiply/round steps to the output register; a negative
// exponent with a nonzero base first forms the reciprocal in a
// restoring divider producing two quotient bits per cycle.
// Each step is a multiply on the shared 32x32 multiplier followed by a
// round and saturate. The next word can be accepted the cycle after the
// result is registered.
// Reset clears the sequencer and the output valid; the datapath holds
// no state across words. When the receiver stalls, the finished word
// waits in the output register and a new word may already be taken and
// computed; it waits in its final state until the output register frees.
// ----------------------------------------------------------------------------
module fixed_point_integer_power (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fpip_pkg::DataW-1:0] in_base,
  input  logic [fpip_pkg::DataW-1:0] in_exponent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fpip_pkg::DataW-1:0] out_power,
  output logic                       out_divide_by_zero
);

  fpip_pkg::cmd_t    cmd;
  fpip_pkg::status_t status;

  fpip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  fpip_datapath u_datapath (
    .clk                (clk),
    .in_base            (in_base),
    .in_exponent        (in_exponent),
    .cmd                (cmd),
    .status             (status),
    .out_power          (out_power),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

// ===== src/fpip_datapath.sv =====
// ----------------------------------------------------------------------------
// fpip_datapath
// Operand registers, two-bit-per-cycle reciprocal divider, shared
// multiply and round/saturate unit, and the output word register.
// ----------------------------------------------------------------------------
module fpip_datapath (
  input  logic                          clk,
  input  logic [fpip_pkg::DataW-1:0]    in_base,
  input  logic [fpip_pkg::DataW-1:0]    in_exponent,
  input  fpip_pkg::cmd_t                cmd,
  output fpip_pkg::status_t             status,
  output logic [fpip_pkg::DataW-1:0]    out_power,
  output logic                          out_divide_by_zero
);

  logic [fpip_pkg::DataW-1:0]        base_r;
  logic signed [fpip_pkg::DataW-1:0] mult_r;
  logic signed [fpip_pkg::DataW-1:0] pw_r;
  logic signed [fpip_pkg::ProdW-1:0] prod_r;
  logic [fpip_pkg::DataW-1:0]        rem_r;
  logic [fpip_pkg::DataW-1:0]        quo_r;
  logic                              dz_r;
  logic                              neg_r;
  logic [fpip_pkg::StepW-1:0]        steps_r;
  logic [fpip_pkg::DataW-1:0]        power_r;
  logic                              dz_out_r;

  logic                              exp_neg;
  logic [fpip_pkg::DataW-1:0]        mag;
  logic [2:0]                        steps_raw;
  logic [fpip_pkg::StepW-1:0]        steps_in;
  logic                              dz_in;
  logic [fpip_pkg::DataW-1:0]        dvsr;
  logic [fpip_pkg::DataW:0]          r1;
  logic [fpip_pkg::DataW:0]          r2;
  logic [fpip_pkg::DataW:0]          r1_nxt;
  logic [fpip_pkg::DataW:0]          r2_nxt;
  logic                              q1;
  logic                              q2;
  logic signed [39:0]                trunc;
  logic signed [40:0]                inc;
  logic [39:0]                       half;
  logic [fpip_pkg::DataW-1:0]        sat_val;

  // load decode
  always_comb begin
    exp_neg   = in_exponent[fpip_pkg::DataW-1];
    mag       = exp_neg ? (~in_exponent + 32'd1) : in_exponent;
    steps_raw = mag[fpip_pkg::DataW-1:fpip_pkg::ExpFracBits];
    steps_in  = (steps_raw > 3'(fpip_pkg::MaxSteps)) ? fpip_pkg::StepW'(fpip_pkg::MaxSteps)
                                                     : steps_raw[fpip_pkg::StepW-1:0];
    dz_in     = exp_neg && (in_base == '0);
  end

  // two restoring division steps per cycle
  always_comb begin
    dvsr = base_r[fpip_pkg::DataW-1] ? (~base_r + 32'd1) : base_r;
    r1   = {rem_r, 1'b0};
    q1   = (r1 >= {1'b0, dvsr});
    r1_nxt = q1 ? (r1 - {1'b0, dvsr}) : r1;
    r2   = {r1_nxt[fpip_pkg::DataW-1:0], cmd.div_first};
    q2   = (r2 >= {1'b0, dvsr});
    r2_nxt = q2 ? (r2 - {1'b0, dvsr}) : r2;
  end

  // round and saturate
  always_comb begin
    trunc = prod_r[fpip_pkg::ProdW-1:fpip_pkg::RoundShift];
    inc   = {trunc[39], trunc} + 41'sd1;
    half  = inc[40:1];
    if (half[39:31] == 9'h000 || half[39:31] == 9'h1ff) begin
      sat_val = half[31:0];
    end else if (half[39]) begin
      sat_val = fpip_pkg::SatMin;
    end else begin
      sat_val = fpip_pkg::SatMax;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r  <= in_base;
      mult_r  <= dz_in ? fpip_pkg::SatMax : in_base;
      pw_r    <= fpip_pkg::OneQ15;
      rem_r   <= '0;
      quo_r   <= '0;
      dz_r    <= dz_in;
      neg_r   <= exp_neg;
      steps_r <= steps_in;
    end
    if (cmd.div_step) begin
      rem_r <= r2_nxt[fpip_pkg::DataW-1:0];
      quo_r <= {quo_r[fpip_pkg::DataW-3:0], q1, q2};
    end
    if (cmd.recip) begin
      mult_r <= base_r[fpip_pkg::DataW-1] ? (~quo_r + 32'd1) : quo_r;
    end
    if (cmd.mul) begin
      prod_r <= pw_r * mult_r;
    end
    if (cmd.rnd) begin
      pw_r <= sat_val;
    end
    if (cmd.out_load) begin
      power_r  <= pw_r;
      dz_out_r <= dz_r;
    end
  end

  assign status.need_div   = neg_r & ~dz_r;
  assign status.steps      = steps_r;
  assign out_power          = power_r;
  assign out_divide_by_zero = dz_out_r;

endmodule

// ===== src/fpip_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpip_ctrl
// Sequencer for one word: setup, reciprocal division, multiply/round loop
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module fpip_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fpip_pkg::status_t status,
  output fpip_pkg::cmd_t    cmd
);

  fpip_pkg::state_t                state_r, state_nxt;
  logic [fpip_pkg::DivCntW-1:0]    div_cnt_r, div_cnt_nxt;
  logic [fpip_pkg::StepW-1:0]      steps_left_r, steps_left_nxt;
  logic                            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fpip_pkg::S_IDLE;
      div_cnt_r    <= '0;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      div_cnt_r    <= div_cnt_nxt;
      steps_left_r <= steps_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    div_cnt_nxt    = div_cnt_r;
    steps_left_nxt = steps_left_r;
    cmd            = '0;
    case (state_r)
      fpip_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fpip_pkg::S_SETUP;
        end
      end
      fpip_pkg::S_SETUP: begin
        steps_left_nxt = status.steps;
        div_cnt_nxt    = '0;
        if (status.need_div) begin
          state_nxt = fpip_pkg::S_DIV;
        end else if (status.steps != '0) begin
          state_nxt = fpip_pkg::S_MUL;
        end else begin
          state_nxt = fpip_pkg::S_DONE;
        end
      end
      fpip_pkg::S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (div_cnt_r == '0);
        div_cnt_nxt   = div_cnt_r + 1'b1;
        if (div_cnt_r == fpip_pkg::DivCntW'(fpip_pkg::DivIters - 1)) begin
          state_nxt = fpip_pkg::S_RECIP;
        end
      end
      fpip_pkg::S_RECIP: begin
        cmd.recip = 1'b1;
        state_nxt = (steps_left_r != '0) ? fpip_pkg::S_MUL : fpip_pkg::S_DONE;
      end
      fpip_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = fpip_pkg::S_RND;
      end
      fpip_pkg::S_RND: begin
        cmd.rnd        = 1'b1;
        steps_left_nxt = steps_left_r - 1'b1;
        state_nxt      = (steps_left_r == fpip_pkg::StepW'(1)) ? fpip_pkg::S_DONE
                                                               : fpip_pkg::S_MUL;
      end
      fpip_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = fpip_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fpip_pkg::S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == fpip_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == fpip_pkg::S_SETUP))
    else $error("accepted word did not enter setup");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.recip, cmd.mul, cmd.rnd, cmd.out_load}))
    else $error("datapath commands overlap");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpip_pkg::S_DIV) |-> (div_cnt_r < fpip_pkg::DivCntW'(fpip_pkg::DivIters)))
    else $error("divider ran past its iteration count");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpip_pkg::S_RND && steps_left_r == fpip_pkg::StepW'(1))
      |=> (state_r == fpip_pkg::S_DONE))
    else $error("multiply loop did not stop after last step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("output word overwritten while stalled");

endmodule

// ===== sim/fixed_point_integer_power_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_integer_power_test
// Self-checking bench for the fixed point integer power block: a directed set
// of corner words, then random words with random gaps and output stalls, all
// scored against a bit-exact predictor of the power and the zero-base flag.
// ----------------------------------------------------------------------------
module fixed_point_integer_power_test;

  localparam int     RandWords  = 1730;
  localparam int     CycleLimit = 1_000_000;
  localparam int     LongHold   = 400;
  localparam int     TailCycles = 100;
  localparam int     RecipShift = 50;
  localparam longint PowMax     = 64'sd2147483647;
  localparam longint PowMin     = -64'sd2147483648;
  localparam logic [fpip_pkg::DataW-1:0] ExpOne  = 32'h2000_0000;
  localparam logic [fpip_pkg::DataW-1:0] ExpLow  = 32'hA000_0000;

  typedef struct {
    logic [fpip_pkg::DataW-1:0] base;
    logic [fpip_pkg::DataW-1:0] exponent;
    logic                       drain_first;
  } power_req_t;

  typedef struct packed {
    logic [fpip_pkg::DataW-1:0] power;
    logic                       divide_by_zero;
  } power_word_t;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic [fpip_pkg::DataW-1:0] in_base     = '0;
  logic [fpip_pkg::DataW-1:0] in_exponent = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [fpip_pkg::DataW-1:0] out_power;
  logic                       out_divide_by_zero;

  power_req_t  pending_q[$];
  power_word_t expected_q[$];
  power_req_t  next_req;
  power_word_t got_word;
  power_word_t want_word;

  logic in_taken     = 1'b0;
  logic out_taken    = 1'b0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   stall_draw   = 0;
  int   words_sent   = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  int   cycle_cnt    = 0;

  fixed_point_integer_power uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_base            (in_base),
    .in_exponent        (in_exponent),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_power          (out_power),
    .out_divide_by_zero (out_divide_by_zero)
  );

  always #2 clk = ~clk;

  function automatic power_word_t predict_power(logic [fpip_pkg::DataW-1:0] base_w,
                                                logic [fpip_pkg::DataW-1:0] exp_w);
    longint      b;
    longint      e;
    longint      neg_e;
    longint      quot;
    longint      mult;
    longint      p;
    int unsigned n;
    power_word_t r;
    b = longint'($signed(base_w));
    e = longint'($signed(exp_w));
    r.divide_by_zero = 1'b0;
    if (e < 0) begin
      neg_e = -e;
      n = neg_e[31:0] >> fpip_pkg::ExpFracBits;
      if (b != 0) begin
        quot = (64'sd1 <<< RecipShift) / b;
        mult = longint'($signed(quot[31:0]));
      end else begin
        mult = PowMax;
        r.divide_by_zero = 1'b1;
      end
    end else begin
      n = exp_w >> fpip_pkg::ExpFracBits;
      mult = b;
    end
    if (n > fpip_pkg::MaxSteps) n = fpip_pkg::MaxSteps;
    p = longint'(fpip_pkg::OneQ15);
    for (int k = 0; k < n; k++) begin
      p = ((p * mult) >>> fpip_pkg::RoundShift) + 1;
      p = p >>> 1;
      if (p > PowMax) p = PowMax;
      if (p < PowMin) p = PowMin;
    end
    r.power = p[31:0];
    return r;
  endfunction

  task automatic add_word(logic [fpip_pkg::DataW-1:0] b, logic [fpip_pkg::DataW-1:0] e,
                          logic drain);
    power_req_t req;
    req.base        = b;
    req.exponent    = e;
    req.drain_first = drain;
    pending_q.push_back(req);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain_first && expected_q.size() != 0)) begin
        next_req = pending_q.pop_front();
        in_base     <= next_req.base;
        in_exponent <= next_req.exponent;
        in_valid    <= 1'b1;
        // every fourth stretch of 150 words goes back to back
        if ((words_sent / 150) % 4 == 2) gap_left <= 0;
        else gap_left <= $urandom_range(0, 19);
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_taken) begin
      if (results_seen == 500) stall_draw = LongHold;
      else if ((results_seen / 150) % 4 == 3) stall_draw = 0;
      else stall_draw = $urandom_range(0, 19);
      if (stall_draw == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= stall_draw - 1;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // scoreboard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        results_seen++;
        got_word.power          = out_power;
        got_word.divide_by_zero = out_divide_by_zero;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word %0d: power %h divide_by_zero %b",
                     results_seen, out_power, out_divide_by_zero);
        end else begin
          want_word = expected_q.pop_front();
          if (got_word.power !== want_word.power ||
              got_word.divide_by_zero !== want_word.divide_by_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: power %h exp %h, divide_by_zero %b exp %b",
                       results_seen, got_word.power, want_word.power,
                       got_word.divide_by_zero, want_word.divide_by_zero);
          end
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_power(in_base, in_exponent));
    end
  end

  initial begin : stimulus
    logic [fpip_pkg::DataW-1:0] b;
    logic [fpip_pkg::DataW-1:0] e;
    logic [fpip_pkg::DataW-1:0] x;
    // one, saturation both ways, extreme bases
    add_word(32'h0000_0000,    32'h0000_0000, 1'b0);
    add_word(fpip_pkg::SatMax, 32'h6000_0000, 1'b0);
    add_word(fpip_pkg::SatMin, 32'h6000_0000, 1'b0);
    add_word(fpip_pkg::SatMin, 32'h2000_0000, 1'b0);
    add_word(fpip_pkg::SatMin, 32'h4000_0000, 1'b0);
    add_word(fpip_pkg::SatMax, 32'hE000_0000, 1'b0);
    add_word(fpip_pkg::SatMin, 32'hE000_0000, 1'b0);
    // zero base with negative exponent, with and without steps, then a positive one
    add_word(32'h0000_0000, 32'hF000_0000, 1'b0);
    add_word(32'h0000_0000, 32'hE000_0000, 1'b0);
    add_word(32'h0000_0000, 32'hA000_0000, 1'b0);
    add_word(32'h0000_0000, 32'h6000_0000, 1'b0);
    // reciprocal wrap
    add_word(32'hFFFF_FFFF, 32'hE000_0000, 1'b0);
    add_word(32'h0000_0001, 32'hE000_0000, 1'b0);
    add_word(32'h0200_0000, 32'hC000_0000, 1'b0);
    add_word(32'h0100_0000, 32'hA000_0000, 1'b0);
    // most negative exponent acts as minus three
    add_word(32'h0400_0000, 32'h8000_0000, 1'b0);
    add_word(32'h0300_0000, 32'h7FFF_FFFF, 1'b0);
    // fraction only exponents, then negative bases
    add_word(32'h0300_0000, 32'h1FFF_FFFF, 1'b0);
    add_word(32'h0300_0000, 32'hE000_0001, 1'b0);
    add_word(32'hFC00_0000, 32'h6000_0000, 1'b0);
    add_word(32'hFF00_0000, 32'hC000_0000, 1'b0);
    for (int i = 0; i < RandWords; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b = $urandom;
        4, 5, 6:    b = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        7: begin
          x = $urandom_range(1, 255);
          b = $urandom_range(0, 1) ? -x : x;
        end
        8: b = '0;
        default: begin
          case ($urandom_range(0, 3))
            0:       b = fpip_pkg::SatMax;
            1:       b = fpip_pkg::SatMin;
            2:       b = '1;
            default: b = 32'd1;
          endcase
        end
      endcase
      if ($urandom_range(0, 19) == 0) begin
        do e = $urandom; while ($signed(e) < $signed(ExpLow));
      end else begin
        e = ($urandom_range(0, 6) - 3) * ExpOne + ($urandom & (ExpOne - 1));
      end
      add_word(b, e, i == 600 || i == 1200);
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
